@@ rtl/fcfs_pkg.sv @@
package fcfs_pkg;

  // Capacity and derived index widths.
  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  // Field widths.
  localparam int TIME_W  = 16;
  localparam int CT_W    = 22;
  localparam int SUM_W   = 26;
  localparam int AVG_W   = 30;
  localparam int FRAC_W  = 8;
  localparam int PNUM_W  = 7;
  localparam int DIVD_W  = SUM_W + FRAC_W;
  localparam int DSTEP_W = $clog2(DIVD_W);

  localparam logic [CT_W-1:0]  CT_MAX  = {CT_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef struct packed {
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] burst_time;
    logic              last_process;
  } in_item_t;

  typedef struct packed {
    logic [PNUM_W-1:0] process_number;
    logic [CT_W-1:0]   completion_time;
    logic [CT_W-1:0]   turnaround_time;
    logic [CT_W-1:0]   waiting_time;
    logic [AVG_W-1:0]  avg_turnaround;
    logic [AVG_W-1:0]  avg_waiting;
    logic              last_result;
  } out_item_t;

  typedef enum logic [2:0] {
    ALU_MAX,
    ALU_ADD_SAT_CT,
    ALU_ADD_SAT_SUM,
    ALU_SUB,
    ALU_SUB_FLOOR
  } alu_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_KEY_RD,
    S_KEY_LD,
    S_CMP_RD,
    S_CMP,
    S_ORD_WR,
    S_W_ORD_RD,
    S_W_ORD_LD,
    S_W_PROC_RD,
    S_W_START,
    S_W_DONE,
    S_W_TAT,
    S_W_WT,
    S_W_TSUM,
    S_W_WSUM,
    S_DT_GO,
    S_DT_WAIT,
    S_DW_GO,
    S_DW_WAIT,
    S_O_RD,
    S_O_TAT,
    S_O_WT,
    S_O_EMIT
  } state_t;

  typedef struct packed {
    logic              ld_we;
    logic [IDX_W-1:0]  ld_addr;
    logic [TIME_W-1:0] ld_arrival;
    logic [TIME_W-1:0] ld_burst;
    logic [IDX_W-1:0]  rd_addr;
    logic              ord_we;
    logic [IDX_W-1:0]  ord_waddr;
    logic [IDX_W-1:0]  ord_wdata;
    logic [IDX_W-1:0]  ord_raddr;
    logic              cmp_we;
    logic [IDX_W-1:0]  cmp_waddr;
    logic [CT_W-1:0]   cmp_wdata;
  } store_ctl_t;

  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [IDX_W-1:0]  order;
    logic [CT_W-1:0]   completion;
  } store_rd_t;

endpackage

@@ rtl/fcfs_store.sv @@
module fcfs_store import fcfs_pkg::*; (
  input  logic       clk,
  input  store_ctl_t ctl,
  output store_rd_t  rd
);

  logic [TIME_W-1:0] arrival_mem_r    [MAX_PROCS];
  logic [TIME_W-1:0] burst_mem_r      [MAX_PROCS];
  logic [IDX_W-1:0]  order_mem_r      [MAX_PROCS];
  logic [CT_W-1:0]   completion_mem_r [MAX_PROCS];

  // All reads are registered; data shows in the cycle after the address.
  always_ff @(posedge clk) begin
    if (ctl.ld_we) begin
      arrival_mem_r[ctl.ld_addr] <= ctl.ld_arrival;
      burst_mem_r[ctl.ld_addr]   <= ctl.ld_burst;
    end
    if (ctl.ord_we) begin
      order_mem_r[ctl.ord_waddr] <= ctl.ord_wdata;
    end
    if (ctl.cmp_we) begin
      completion_mem_r[ctl.cmp_waddr] <= ctl.cmp_wdata;
    end
    rd.arrival    <= arrival_mem_r[ctl.rd_addr];
    rd.burst      <= burst_mem_r[ctl.rd_addr];
    rd.completion <= completion_mem_r[ctl.rd_addr];
    rd.order      <= order_mem_r[ctl.ord_raddr];
  end

endmodule

@@ rtl/fcfs_alu.sv @@
module fcfs_alu import fcfs_pkg::*; (
  input  alu_op_t          op,
  input  logic [SUM_W-1:0] a,
  input  logic [SUM_W-1:0] b,
  output logic [SUM_W-1:0] res,
  output logic             lt,
  output logic             eq
);

  logic [SUM_W:0] sum;
  logic [SUM_W:0] diff;

  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = {1'b0, a} - {1'b0, b};
  assign lt   = diff[SUM_W];
  assign eq   = (a == b);

  always_comb begin
    unique case (op)
      ALU_MAX:         res = lt ? b : a;
      ALU_ADD_SAT_CT:  res = (sum > {{(SUM_W-CT_W+1){1'b0}}, CT_MAX}) ?
                             SUM_W'(CT_MAX) : sum[SUM_W-1:0];
      ALU_ADD_SAT_SUM: res = sum[SUM_W] ? SUM_MAX : sum[SUM_W-1:0];
      ALU_SUB:         res = diff[SUM_W-1:0];
      ALU_SUB_FLOOR:   res = lt ? '0 : diff[SUM_W-1:0];
      default:         res = '0;
    endcase
  end

endmodule

@@ rtl/fcfs_div.sv @@
module fcfs_div import fcfs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [AVG_W-1:0]  quotient
);

  logic               run_r, run_nxt;
  logic               done_r, done_nxt;
  logic [DSTEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]   div_r, div_nxt;
  logic [DIVD_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W:0]     trial;
  logic               ge;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem_r, quo_r[DIVD_W-1]};
  assign ge    = (trial >= {1'b0, div_r});

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    quo_nxt  = quo_r;
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      div_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (run_r) begin
      rem_nxt  = ge ? CNT_W'(trial - {1'b0, div_r}) : CNT_W'(trial);
      quo_nxt  = {quo_r[DIVD_W-2:0], ge};
      step_nxt = step_r + DSTEP_W'(1);
      if (step_r == DSTEP_W'(DIVD_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    quo_r  <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r[AVG_W-1:0];

endmodule

@@ rtl/fcfs_schedule_calculator.sv @@
// First-come-first-served schedule calculator.
//
// Input channel: a transaction is taken at a rising edge where start is high
// and busy is low. Each transaction loads one process (arrival, burst); the
// processes are numbered from 1 in load order. Busy stays low during loading,
// so transactions may come back to back. Transactions beyond MAX_PROCS are
// dropped, but a dropped one that carries last_process still starts the run.
//
// The transaction marked last_process raises busy. A small sequencer drives
// one shared add/subtract/compare unit through a stable rank-by-arrival sort,
// the scheduling walk, two bit-serial divisions for the averages and the
// result phase. The length of a run is set by the single read port per store
// and the shared unit; the next set can load as soon as busy falls.
//
// Result channel: out_valid pulses for one cycle per result, in load order,
// and the receiver cannot stall. The last result carries last_result and both
// averages and shows in the first cycle with busy low. Synchronous reset clears
// the load count, running clock and sums; process stores hold garbage until loaded.
module fcfs_schedule_calculator import fcfs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  p_r, p_nxt;
  logic [IDX_W-1:0]  q_r, q_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [IDX_W-1:0]  rank_r, rank_nxt;
  logic [IDX_W-1:0]  proc_r, proc_nxt;
  logic [TIME_W-1:0] key_r, key_nxt;
  logic [TIME_W-1:0] arr_r, arr_nxt;
  logic [TIME_W-1:0] bur_r, bur_nxt;
  logic [CT_W-1:0]   start_r, start_nxt;
  logic [CT_W-1:0]   clock_r, clock_nxt;
  logic [CT_W-1:0]   tat_r, tat_nxt;
  logic [CT_W-1:0]   wt_r, wt_nxt;
  logic [CT_W-1:0]   comp_r, comp_nxt;
  logic [SUM_W-1:0]  tsum_r, tsum_nxt;
  logic [SUM_W-1:0]  wsum_r, wsum_nxt;
  logic [AVG_W-1:0]  avg_t_r, avg_t_nxt;
  logic [AVG_W-1:0]  avg_w_r, avg_w_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  store_ctl_t        st_ctl;
  store_rd_t         st_rd;
  alu_op_t           alu_op;
  logic [SUM_W-1:0]  alu_a, alu_b, alu_res;
  logic              alu_lt, alu_eq;
  logic              div_start, div_done;
  logic [DIVD_W-1:0] div_dividend;
  logic [AVG_W-1:0]  div_quo;

  logic              accept;
  logic              room;
  logic [CNT_W-1:0]  last_idx;
  logic              p_last, q_last, i_last;
  logic              less;

  assign accept   = start && (state_r == S_IDLE);
  assign room     = (cnt_r < CNT_W'(MAX_PROCS));
  assign last_idx = cnt_r - CNT_W'(1);
  assign p_last   = (CNT_W'(p_r) == last_idx);
  assign q_last   = (CNT_W'(q_r) == last_idx);
  assign i_last   = (CNT_W'(i_r) == last_idx);

  // Stable ordering: q ranks ahead of p on an earlier arrival, or on an
  // equal arrival when q was loaded first.
  assign less = alu_lt || (alu_eq && (q_r < p_r));

  fcfs_store u_store (
    .clk (clk),
    .ctl (st_ctl),
    .rd  (st_rd)
  );

  fcfs_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .lt  (alu_lt),
    .eq  (alu_eq)
  );

  fcfs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (accept && in_item.last_process) begin
                     state_nxt = S_KEY_RD;
                   end
      S_KEY_RD:    state_nxt = S_KEY_LD;
      S_KEY_LD:    state_nxt = S_CMP_RD;
      S_CMP_RD:    state_nxt = S_CMP;
      S_CMP:       state_nxt = q_last ? S_ORD_WR : S_CMP_RD;
      S_ORD_WR:    state_nxt = p_last ? S_W_ORD_RD : S_KEY_RD;
      S_W_ORD_RD:  state_nxt = S_W_ORD_LD;
      S_W_ORD_LD:  state_nxt = S_W_PROC_RD;
      S_W_PROC_RD: state_nxt = S_W_START;
      S_W_START:   state_nxt = S_W_DONE;
      S_W_DONE:    state_nxt = S_W_TAT;
      S_W_TAT:     state_nxt = S_W_WT;
      S_W_WT:      state_nxt = S_W_TSUM;
      S_W_TSUM:    state_nxt = S_W_WSUM;
      S_W_WSUM:    state_nxt = i_last ? S_DT_GO : S_W_ORD_RD;
      S_DT_GO:     state_nxt = S_DT_WAIT;
      S_DT_WAIT:   if (div_done) begin
                     state_nxt = S_DW_GO;
                   end
      S_DW_GO:     state_nxt = S_DW_WAIT;
      S_DW_WAIT:   if (div_done) begin
                     state_nxt = S_O_RD;
                   end
      S_O_RD:      state_nxt = S_O_TAT;
      S_O_TAT:     state_nxt = S_O_WT;
      S_O_WT:      state_nxt = S_O_EMIT;
      S_O_EMIT:    state_nxt = i_last ? S_IDLE : S_O_RD;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Control outputs: store ports, shared unit operands and divider launch.
  always_comb begin
    st_ctl            = '0;
    st_ctl.ld_we      = accept && room;
    st_ctl.ld_addr    = cnt_r[IDX_W-1:0];
    st_ctl.ld_arrival = in_item.arrival_time;
    st_ctl.ld_burst   = in_item.burst_time;
    st_ctl.ord_waddr  = rank_r;
    st_ctl.ord_wdata  = p_r;
    st_ctl.ord_raddr  = i_r;
    st_ctl.cmp_waddr  = proc_r;
    st_ctl.cmp_wdata  = alu_res[CT_W-1:0];
    alu_op            = ALU_SUB;
    alu_a             = '0;
    alu_b             = '0;
    div_start         = 1'b0;
    div_dividend      = {tsum_r, FRAC_W'(0)};
    unique case (state_r)
      S_KEY_RD:    st_ctl.rd_addr = p_r;
      S_CMP_RD:    st_ctl.rd_addr = q_r;
      S_CMP: begin
        alu_a = SUM_W'(st_rd.arrival);
        alu_b = SUM_W'(key_r);
      end
      S_ORD_WR:    st_ctl.ord_we = 1'b1;
      S_W_PROC_RD: st_ctl.rd_addr = proc_r;
      S_W_START: begin
        alu_op = ALU_MAX;
        alu_a  = SUM_W'(clock_r);
        alu_b  = SUM_W'(st_rd.arrival);
      end
      S_W_DONE: begin
        alu_op        = ALU_ADD_SAT_CT;
        alu_a         = SUM_W'(start_r);
        alu_b         = SUM_W'(bur_r);
        st_ctl.cmp_we = 1'b1;
      end
      S_W_TAT: begin
        alu_a = SUM_W'(clock_r);
        alu_b = SUM_W'(arr_r);
      end
      S_W_WT, S_O_WT: begin
        alu_op = ALU_SUB_FLOOR;
        alu_a  = SUM_W'(tat_r);
        alu_b  = SUM_W'(bur_r);
      end
      S_W_TSUM: begin
        alu_op = ALU_ADD_SAT_SUM;
        alu_a  = tsum_r;
        alu_b  = SUM_W'(tat_r);
      end
      S_W_WSUM: begin
        alu_op = ALU_ADD_SAT_SUM;
        alu_a  = wsum_r;
        alu_b  = SUM_W'(wt_r);
      end
      S_DT_GO:     div_start = 1'b1;
      S_DW_GO: begin
        div_start    = 1'b1;
        div_dividend = {wsum_r, FRAC_W'(0)};
      end
      S_O_RD:      st_ctl.rd_addr = i_r;
      S_O_TAT: begin
        alu_a = SUM_W'(st_rd.completion);
        alu_b = SUM_W'(st_rd.arrival);
      end
      default: begin
      end
    endcase
  end

  // Datapath register updates.
  always_comb begin
    cnt_nxt       = cnt_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    i_nxt         = i_r;
    rank_nxt      = rank_r;
    proc_nxt      = proc_r;
    key_nxt       = key_r;
    arr_nxt       = arr_r;
    bur_nxt       = bur_r;
    start_nxt     = start_r;
    clock_nxt     = clock_r;
    tat_nxt       = tat_r;
    wt_nxt        = wt_r;
    comp_nxt      = comp_r;
    tsum_nxt      = tsum_r;
    wsum_nxt      = wsum_r;
    avg_t_nxt     = avg_t_r;
    avg_w_nxt     = avg_w_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && room) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        p_nxt    = '0;
        q_nxt    = '0;
        rank_nxt = '0;
      end
      S_KEY_LD: begin
        key_nxt = st_rd.arrival;
        q_nxt   = '0;
      end
      S_CMP: begin
        if (less) begin
          rank_nxt = rank_r + IDX_W'(1);
        end
        q_nxt = q_r + IDX_W'(1);
      end
      S_ORD_WR: begin
        rank_nxt = '0;
        p_nxt    = p_r + IDX_W'(1);
        i_nxt    = '0;
      end
      S_W_ORD_LD:  proc_nxt = st_rd.order;
      S_W_START: begin
        start_nxt = alu_res[CT_W-1:0];
        arr_nxt   = st_rd.arrival;
        bur_nxt   = st_rd.burst;
      end
      S_W_DONE:    clock_nxt = alu_res[CT_W-1:0];
      S_W_TAT:     tat_nxt = alu_res[CT_W-1:0];
      S_W_WT:      wt_nxt = alu_res[CT_W-1:0];
      S_W_TSUM:    tsum_nxt = alu_res;
      S_W_WSUM: begin
        wsum_nxt = alu_res;
        i_nxt    = i_last ? '0 : i_r + IDX_W'(1);
      end
      S_DT_WAIT:   if (div_done) begin
                     avg_t_nxt = div_quo;
                   end
      S_DW_WAIT:   if (div_done) begin
                     avg_w_nxt = div_quo;
                   end
      S_O_TAT: begin
        tat_nxt  = alu_res[CT_W-1:0];
        comp_nxt = st_rd.completion;
        bur_nxt  = st_rd.burst;
      end
      S_O_WT:      wt_nxt = alu_res[CT_W-1:0];
      S_O_EMIT: begin
        out_valid_nxt                = 1'b1;
        out_item_nxt.process_number  = PNUM_W'(i_r) + PNUM_W'(1);
        out_item_nxt.completion_time = comp_r;
        out_item_nxt.turnaround_time = tat_r;
        out_item_nxt.waiting_time    = wt_r;
        out_item_nxt.avg_turnaround  = i_last ? avg_t_r : '0;
        out_item_nxt.avg_waiting     = i_last ? avg_w_r : '0;
        out_item_nxt.last_result     = i_last;
        i_nxt                        = i_r + IDX_W'(1);
        if (i_last) begin
          // The run is over; the next transaction opens a new set.
          cnt_nxt   = '0;
          clock_nxt = '0;
          tsum_nxt  = '0;
          wsum_nxt  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      clock_r     <= '0;
      tsum_r      <= '0;
      wsum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clock_r     <= clock_nxt;
      tsum_r      <= tsum_nxt;
      wsum_r      <= wsum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    i_r        <= i_nxt;
    rank_r     <= rank_nxt;
    proc_r     <= proc_nxt;
    key_r      <= key_nxt;
    arr_r      <= arr_nxt;
    bur_r      <= bur_nxt;
    start_r    <= start_nxt;
    tat_r      <= tat_nxt;
    wt_r       <= wt_nxt;
    comp_r     <= comp_nxt;
    avg_t_r    <= avg_t_nxt;
    avg_w_r    <= avg_w_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Only the final result of a run coincides with the block going idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy == !out_item.last_result))
    else $error("last_result does not match the end of the run");

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_PROCS))
    else $error("load count above capacity");

  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.last_process) |=> busy)
    else $error("final process did not start the run");

  // A sort rank always lands inside the loaded set.
  a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ORD_WR) |-> (CNT_W'(rank_r) < cnt_r))
    else $error("sort rank outside the loaded set");

endmodule

@@ test/tb_top.sv @@
module tb_top import fcfs_pkg::*; ();

  // The scoreboard keeps its own copy of the process stores and the loaded
  // count. When an accepted transaction carries last_process it computes the
  // whole schedule in one go and queues one expected result per process, in
  // load order, which is the order in which the block emits them.
  class fcfs_scoreboard;
    logic [TIME_W-1:0] arrivals[MAX_PROCS];
    logic [TIME_W-1:0] bursts[MAX_PROCS];
    int unsigned       loaded;
    out_item_t         schedule_q[$];
    int unsigned       errors;

    function new();
      loaded = 0;
      errors = 0;
    endfunction

    // Note one accepted input transaction. A process that finds the stores
    // full is dropped, but its last mark still starts the run.
    function void note_process(in_item_t it);
      if (loaded < MAX_PROCS) begin
        arrivals[loaded] = it.arrival_time;
        bursts[loaded]   = it.burst_time;
        loaded++;
      end
      if (it.last_process) begin
        compute_schedule();
      end
    endfunction

    function void compute_schedule();
      int unsigned        n;
      int unsigned        pos;
      int unsigned        served[MAX_PROCS];
      logic [CT_W-1:0]    done_at[MAX_PROCS];
      logic [CT_W-1:0]    clock_now;
      logic [CT_W-1:0]    begin_at;
      logic [CT_W:0]      raw_done;
      logic [CT_W-1:0]    tat;
      logic [CT_W-1:0]    wt;
      logic [SUM_W-1:0]   tat_sum;
      logic [SUM_W-1:0]   wt_sum;
      logic [SUM_W:0]     raw_sum;
      logic [DIVD_W-1:0]  quot;
      out_item_t          res;
      n         = loaded;
      clock_now = '0;
      tat_sum   = '0;
      wt_sum    = '0;
      // Stable ordering by arrival: a process's slot is the number of
      // processes that arrive strictly earlier, plus the earlier-loaded ones
      // with the same arrival.
      for (int i = 0; i < n; i++) begin
        pos = 0;
        for (int j = 0; j < n; j++) begin
          if (arrivals[j] < arrivals[i] || (arrivals[j] == arrivals[i] && j < i)) begin
            pos++;
          end
        end
        served[pos] = i;
      end
      // Serve in arrival order. An idle gap lets the clock jump forward to
      // the arrival; the completion saturates at the 22-bit maximum.
      for (int k = 0; k < n; k++) begin
        automatic int unsigned p = served[k];
        begin_at = (clock_now > CT_W'(arrivals[p])) ? clock_now : CT_W'(arrivals[p]);
        raw_done = {1'b0, begin_at} + (CT_W + 1)'(bursts[p]);
        done_at[p] = (raw_done > (CT_W + 1)'(CT_MAX)) ? CT_MAX : raw_done[CT_W-1:0];
        clock_now  = done_at[p];
        tat = done_at[p] - CT_W'(arrivals[p]);
        wt  = (tat > CT_W'(bursts[p])) ? tat - CT_W'(bursts[p]) : '0;
        raw_sum = {1'b0, tat_sum} + (SUM_W + 1)'(tat);
        tat_sum = (raw_sum > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : raw_sum[SUM_W-1:0];
        raw_sum = {1'b0, wt_sum} + (SUM_W + 1)'(wt);
        wt_sum  = (raw_sum > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : raw_sum[SUM_W-1:0];
      end
      // Results leave in load order; only the final one carries the averages.
      for (int i = 0; i < n; i++) begin
        res = '0;
        res.process_number  = PNUM_W'(i + 1);
        res.completion_time = done_at[i];
        res.turnaround_time = done_at[i] - CT_W'(arrivals[i]);
        res.waiting_time    = (res.turnaround_time > CT_W'(bursts[i])) ?
                              res.turnaround_time - CT_W'(bursts[i]) : '0;
        if (i + 1 == n) begin
          quot = {tat_sum, {FRAC_W{1'b0}}} / DIVD_W'(n);
          res.avg_turnaround = quot[AVG_W-1:0];
          quot = {wt_sum, {FRAC_W{1'b0}}} / DIVD_W'(n);
          res.avg_waiting = quot[AVG_W-1:0];
          res.last_result = 1'b1;
        end
        schedule_q.push_back(res);
      end
      loaded = 0;
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch %s: got %0h, expected %0h", what, got, want);
    endtask

    // Compare one emitted result with the oldest outstanding expectation.
    task check_result(out_item_t got);
      out_item_t want;
      if (schedule_q.size() == 0) begin
        report_mismatch("unexpected result, process", got.process_number, 0);
      end else begin
        want = schedule_q.pop_front();
        if (got.process_number !== want.process_number)
          report_mismatch("process_number", got.process_number, want.process_number);
        if (got.completion_time !== want.completion_time)
          report_mismatch("completion_time", got.completion_time, want.completion_time);
        if (got.turnaround_time !== want.turnaround_time)
          report_mismatch("turnaround_time", got.turnaround_time, want.turnaround_time);
        if (got.waiting_time !== want.waiting_time)
          report_mismatch("waiting_time", got.waiting_time, want.waiting_time);
        if (got.avg_turnaround !== want.avg_turnaround)
          report_mismatch("avg_turnaround", got.avg_turnaround, want.avg_turnaround);
        if (got.avg_waiting !== want.avg_waiting)
          report_mismatch("avg_waiting", got.avg_waiting, want.avg_waiting);
        if (got.last_result !== want.last_result)
          report_mismatch("last_result", got.last_result, want.last_result);
      end
    endtask
  endclass

  // The longest stretch without any transaction is one full run over sixteen
  // processes before its first result, plus a sender gap; the limit covers
  // that stretch many times over.
  localparam int QUIET_LIMIT  = 20000;
  localparam int RANDOM_ITEMS = 395;
  localparam int CALM_TAIL    = 60;
  localparam int DRAIN_CYCLES = 32;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  fcfs_scoreboard sb = new();
  int  quiet_cycles = 0;
  bit  sender_idles = 1'b1;
  int  stored_total = 0;

  fcfs_schedule_calculator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // Monitor. Both channels are sampled at the rising edge, where the block's
  // own outputs still show their values from the cycle that edge ends. The
  // result is checked before the input is noted: a result in the cycle where
  // busy falls belongs to the run that is ending, never to a run that an
  // input transaction in the same cycle might start.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if (out_valid) begin
        sb.check_result(out_item);
      end
      if (start && !busy) begin
        sb.note_process(in_item);
      end
      if (out_valid || (start && !busy)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Watchdog: ends the run if the block stops moving transactions.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, sb.schedule_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic in_item_t make_item(logic [TIME_W-1:0] arr, logic [TIME_W-1:0] bst,
                                         logic last);
    in_item_t it;
    it.arrival_time = arr;
    it.burst_time   = bst;
    it.last_process = last;
    return it;
  endfunction

  // Time values in a few ranges: narrow ranges give many equal arrivals and
  // back-to-back service, the full range gives idle gaps and large clocks.
  function automatic logic [TIME_W-1:0] pick_time(int unsigned mode);
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 1) ? {TIME_W{1'b1}} : '0;
    end
    case (mode)
      0: return TIME_W'($urandom_range(0, 65535));
      1: return TIME_W'($urandom_range(0, 15));
      2: return TIME_W'($urandom_range(0, 1023));
      default: return TIME_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Drive one input transaction and return at the edge that accepts it.
  // While idling is on, a random gap with start low may come first; the
  // gap can fall during loading or anywhere in a run.
  task automatic send_process(in_item_t it);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // One set of processes; only the final one carries the last mark. Sets
  // longer than the capacity have their extra processes dropped.
  task automatic send_random_set(int unsigned count);
    int unsigned arr_mode;
    int unsigned bst_mode;
    arr_mode = $urandom_range(0, 3);
    bst_mode = $urandom_range(0, 3);
    for (int k = 0; k < count; k++) begin
      send_process(make_item(pick_time(arr_mode), pick_time(bst_mode), k == count - 1));
      if (k < MAX_PROCS) begin
        stored_total++;
      end
    end
  endtask

  initial begin
    int unsigned pick;
    int unsigned count;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A single process at both extremes of the fields.
    send_process(make_item('0, '0, 1'b1));
    send_process(make_item({TIME_W{1'b1}}, {TIME_W{1'b1}}, 1'b1));
    // An idle gap: the clock sits below the second arrival.
    send_process(make_item(16'd10, 16'd5, 1'b0));
    send_process(make_item(16'd100, 16'd3, 1'b1));
    // Loaded out of arrival order, with equal arrivals that keep load order,
    // and a process that waits behind a long burst.
    send_process(make_item(16'd50, 16'd7, 1'b0));
    send_process(make_item(16'd20, 16'd4, 1'b0));
    send_process(make_item(16'd50, 16'd1, 1'b0));
    send_process(make_item(16'd0, {TIME_W{1'b1}}, 1'b1));
    // A full set of maximum bursts with alternating extreme arrivals, then
    // one more process that finds the stores full; its last mark still
    // starts the run over the sixteen stored ones.
    for (int k = 0; k < MAX_PROCS; k++) begin
      send_process(make_item((k % 2) ? '0 : {TIME_W{1'b1}}, {TIME_W{1'b1}}, 1'b0));
    end
    send_process(make_item(16'd123, 16'd456, 1'b1));

    // Random part: mostly short sets, a few full ones, and some that run
    // past the capacity. Idling stops for the last stretch of the run.
    while (stored_total < RANDOM_ITEMS) begin
      if (stored_total >= RANDOM_ITEMS - CALM_TAIL) begin
        sender_idles = 1'b0;
      end
      pick = $urandom_range(0, 9);
      if (pick <= 5) count = $urandom_range(1, 4);
      else if (pick <= 7) count = $urandom_range(5, 12);
      else if (pick == 8) count = $urandom_range(13, MAX_PROCS);
      else count = $urandom_range(MAX_PROCS + 1, MAX_PROCS + 3);
      send_random_set(count);
    end
    start <= 1'b0;

    // Let the monitor note the last transaction, then wait for every
    // outstanding result and a short tail for anything stray.
    @(posedge clk);
    while (sb.schedule_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.schedule_q.size() != 0) begin
      sb.report_mismatch("results never emitted", sb.schedule_q.size(), 0);
    end
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
